[design/posv_pkg.sv]
`timescale 1ns / 1ps

package posv_pkg;

  // Field widths on the stream ports
  localparam int unsigned COORD_FIELD_BITS = 32;
  localparam int unsigned IN_TDATA_BITS    = 2 * COORD_FIELD_BITS;
  localparam int unsigned OUT_TDATA_BITS   = 8;

  // Defaults for the top-level parameters
  localparam int unsigned COORD_BITS_DEF   = 32;
  localparam int unsigned MAX_VERTICES_DEF = 65535;

  // Cross products in flight per vertex: one for a plain vertex, up to three
  // for the closing vertex of a ring
  localparam int unsigned NUM_SLOTS = 3;

  // Slot roles
  localparam int unsigned SLOT_LAST  = 0;  // older, recent, newest
  localparam int unsigned SLOT_WRAP  = 1;  // recent, newest, first
  localparam int unsigned SLOT_CLOSE = 2;  // closing vertex, first, second

endpackage : posv_pkg

[design/polygon_orientation_sign_vote.sv]
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit first)                        tlast          tuser
// s_axis    in   x_coord[31:0], y_coord[63:32]                final_vertex   -
// m_axis    out  positive_orientation[0], zero pad [7:1]      -              too_few_vertices
//
// One vertex transaction is taken every cycle unless the pipe is stalled behind
// a pending result; a plain vertex yields no result. The closing vertex yields
// one result, carried through a 3-stage pipe: operand set-up, multiply,
// compare, then the tally and output register. Reset clears the pipe valids,
// the vertex counter and the tally. A stalled output holds back the closing
// vertex of the next ring and what follows it; plain vertices ahead of it keep flowing.
module polygon_orientation_sign_vote #(
  parameter int unsigned COORD_BITS   = posv_pkg::COORD_BITS_DEF,
  parameter int unsigned MAX_VERTICES = posv_pkg::MAX_VERTICES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [posv_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,   // x_coord, y_coord
  input  logic                                   s_axis_tlast,   // final_vertex
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [posv_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,   // positive_orientation, pad
  output logic                                   m_axis_tuser    // too_few_vertices
);
  import posv_pkg::*;

  // Widths: coordinate differences, products, their difference, counters
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned ZW = PW + 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned TW = CW + 1;
  localparam int unsigned SW = TW + 1;

  localparam logic [CW-1:0]        SEEN_MAX = CW'(MAX_VERTICES);
  localparam logic signed [SW-1:0] TALLY_HI = SW'(MAX_VERTICES);
  localparam logic signed [SW-1:0] TALLY_LO = -TALLY_HI;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;
  typedef logic signed [PW-1:0]         prod_t;

  typedef struct packed {
    diff_t a;
    diff_t b;
    diff_t c;
    diff_t d;
  } cross_ops_t;

  typedef struct packed {
    logic                 fin;
    logic                 few;
    logic [NUM_SLOTS-1:0] vote;
  } item_ctrl_t;

  function automatic diff_t diff(input coord_t u, input coord_t v);
    return DW'(u) - DW'(v);
  endfunction

  // Edge operands of triple (i, j, k): z = a*b - c*d
  function automatic cross_ops_t cross_ops(input coord_t xi, input coord_t yi,
                                           input coord_t xj, input coord_t yj,
                                           input coord_t xk, input coord_t yk);
    cross_ops_t o;
    o.a = diff(xj, xi);
    o.b = diff(yk, yj);
    o.c = diff(xk, xj);
    o.d = diff(yj, yi);
    return o;
  endfunction

  // ---------------------------------------------------------------- ring state
  coord_t start_x_q, start_y_q, second_x_q, second_y_q;
  coord_t older_x_q, older_y_q, recent_x_q, recent_y_q;
  logic [CW-1:0] seen_q, seen_d;

  coord_t cur_x, cur_y;
  assign cur_x = s_axis_tdata[COORD_BITS-1:0];
  assign cur_y = s_axis_tdata[COORD_FIELD_BITS +: COORD_BITS];

  // ---------------------------------------------------------------- pipe regs
  logic                            s0_valid_q, s1_valid_q, s2_valid_q;
  item_ctrl_t                      s0_ctrl_q, s1_ctrl_q, s2_ctrl_q;
  cross_ops_t [NUM_SLOTS-1:0]      s0_ops_q;
  prod_t      [NUM_SLOTS-1:0]      s1_p1_q, s1_p2_q;
  logic       [NUM_SLOTS-1:0]      s2_pos_q, s2_neg_q;
  logic signed [TW-1:0]            tally_q, tally_d;
  logic                            out_pos_q, out_few_q;
  logic                            out_valid_q;

  // ---------------------------------------------------------------- flow control
  logic out_ok, s2_ready, s1_ready, s0_ready, s2_take, in_take;

  // Only a closing vertex needs the output register
  assign out_ok   = !s2_ctrl_q.fin || !out_valid_q || m_axis_tready;
  assign s2_take  = s2_valid_q && out_ok;
  assign s2_ready = !s2_valid_q || out_ok;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s0_ready = !s0_valid_q || s1_ready;
  assign s_axis_tready = s0_ready;
  assign in_take  = s_axis_tvalid && s0_ready;

  // ---------------------------------------------------------------- operand set-up
  logic                       rep, few;
  item_ctrl_t                 in_ctrl;
  cross_ops_t [NUM_SLOTS-1:0] in_ops;

  always_comb begin
    // A lone vertex counts as repeating itself
    rep = (seen_q == '0) || (cur_x == start_x_q && cur_y == start_y_q);
    few = rep ? (seen_q < CW'(3)) : (seen_q < CW'(2));

    in_ctrl.fin  = s_axis_tlast;
    in_ctrl.few  = s_axis_tlast && few;
    in_ctrl.vote = '0;
    if (!s_axis_tlast) begin
      in_ctrl.vote[SLOT_LAST] = (seen_q >= CW'(2));
    end else if (!few) begin
      in_ctrl.vote[SLOT_LAST]  = 1'b1;
      in_ctrl.vote[SLOT_WRAP]  = 1'b1;
      in_ctrl.vote[SLOT_CLOSE] = !rep;
    end

    // Drop a repeated closing vertex: the ring then wraps onto the first one
    if (s_axis_tlast && rep) begin
      in_ops[SLOT_LAST] = cross_ops(older_x_q, older_y_q, recent_x_q, recent_y_q,
                                    start_x_q, start_y_q);
      in_ops[SLOT_WRAP] = cross_ops(recent_x_q, recent_y_q, start_x_q, start_y_q,
                                    second_x_q, second_y_q);
    end else begin
      in_ops[SLOT_LAST] = cross_ops(older_x_q, older_y_q, recent_x_q, recent_y_q,
                                    cur_x, cur_y);
      in_ops[SLOT_WRAP] = cross_ops(recent_x_q, recent_y_q, cur_x, cur_y,
                                    start_x_q, start_y_q);
    end
    in_ops[SLOT_CLOSE] = cross_ops(cur_x, cur_y, start_x_q, start_y_q,
                                   second_x_q, second_y_q);

    // Count vertices, saturating; restart on the closing vertex
    if (s_axis_tlast) begin
      seen_d = '0;
    end else if (seen_q != SEEN_MAX) begin
      seen_d = seen_q + CW'(1);
    end else begin
      seen_d = seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (in_take) begin
      seen_q <= seen_d;
    end
  end

  // Vertex history: payload only
  always_ff @(posedge clk_i) begin
    if (in_take && !s_axis_tlast) begin
      if (seen_q == '0) begin
        start_x_q <= cur_x;
        start_y_q <= cur_y;
      end
      if (seen_q == CW'(1)) begin
        second_x_q <= cur_x;
        second_y_q <= cur_y;
      end
      older_x_q  <= recent_x_q;
      older_y_q  <= recent_y_q;
      recent_x_q <= cur_x;
      recent_y_q <= cur_y;
    end
  end

  // ---------------------------------------------------------------- pipe valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tally_q     <= '0;
    end else begin
      if (s0_ready) begin
        s0_valid_q <= s_axis_tvalid;
      end
      if (s1_ready) begin
        s1_valid_q <= s0_valid_q;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s2_take) begin
        tally_q <= s2_ctrl_q.fin ? '0 : tally_d;
      end
      if (s2_take && s2_ctrl_q.fin) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- multiply, compare
  logic [NUM_SLOTS-1:0] z_pos, z_neg;

  always_comb begin
    logic signed [ZW-1:0] z;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      z = ZW'(s1_p1_q[s]) - ZW'(s1_p2_q[s]);
      z_neg[s] = z[ZW-1];
      z_pos[s] = !z[ZW-1] && (z != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && s_axis_tvalid) begin
      s0_ctrl_q <= in_ctrl;
      s0_ops_q  <= in_ops;
    end
    if (s1_ready && s0_valid_q) begin
      s1_ctrl_q <= s0_ctrl_q;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        s1_p1_q[s] <= s0_ops_q[s].a * s0_ops_q[s].b;
        s1_p2_q[s] <= s0_ops_q[s].c * s0_ops_q[s].d;
      end
    end
    if (s2_ready && s1_valid_q) begin
      s2_ctrl_q <= s1_ctrl_q;
      s2_pos_q  <= z_pos;
      s2_neg_q  <= z_neg;
    end
  end

  // ---------------------------------------------------------------- tally
  // Apply the votes in ring order, clamping after each one
  always_comb begin
    logic signed [SW-1:0] acc;
    acc = SW'(tally_q);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (s2_ctrl_q.vote[s]) begin
        if (s2_pos_q[s]) begin
          acc = acc + SW'(1);
        end else if (s2_neg_q[s]) begin
          acc = acc - SW'(1);
        end
        if (acc > TALLY_HI) begin
          acc = TALLY_HI;
        end else if (acc < TALLY_LO) begin
          acc = TALLY_LO;
        end
      end
    end
    tally_d = acc[TW-1:0];
  end

  // Positive means sign bit clear and not zero
  always_ff @(posedge clk_i) begin
    if (s2_take && s2_ctrl_q.fin) begin
      out_few_q <= s2_ctrl_q.few;
      out_pos_q <= !s2_ctrl_q.few && !tally_d[TW-1] && (tally_d != '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_BITS-1){1'b0}}, out_pos_q};
  assign m_axis_tuser  = out_few_q;

  // ---------------------------------------------------------------- checks
  a_few_not_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_few_q && out_pos_q))
    else $error("degenerate ring reported as positive");

  a_tally_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(tally_q) <= TALLY_HI) && (SW'(tally_q) >= TALLY_LO))
    else $error("tally outside saturation bounds");

  a_seen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SEEN_MAX)
    else $error("vertex counter past its limit");

  a_ring_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && s_axis_tlast) |=> (seen_q == '0))
    else $error("vertex counter not cleared after closing vertex");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_take && s2_ctrl_q.fin) |-> (!out_valid_q || m_axis_tready))
    else $error("pending result overwritten");

endmodule : polygon_orientation_sign_vote
